/* hdl/alu128_pkg.sv */
// shared types and constants for the 128-bit integer alu
package alu128_pkg;

	localparam int HALF_BITS  = 64;
	localparam int FULL_BITS  = 128;
	localparam int SHAMT_BITS = 7;
	localparam int LIMB_BITS  = 32;
	localparam int DEF_WORD_BITS  = 128;
	localparam int DEF_FIFO_DEPTH = 4;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_AND = 4'd4,
		OP_OR  = 4'd5,
		OP_XOR = 4'd6,
		OP_NOT = 4'd7,
		OP_SHL = 4'd8,
		OP_NOP = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_DIV_ZERO   = 2'd1,
		ERR_SHIFT_ZERO = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MUL_END,
		ST_DIV,
		ST_DIV_END
	} st_t;

	// control part of a queued transaction
	typedef struct packed {
		op_t                   op;
		err_t                  err;
		logic                  flip;
		logic [SHAMT_BITS-1:0] shamt;
	} ctl_t;

endpackage

/* hdl/alu128_front.sv */
// front end: decodes opcode, folds special cases, takes divide magnitudes
module alu128_front
	import alu128_pkg::*;
#(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic [3:0]            opcode,
	input  logic [WORD_BITS-1:0]  a,
	input  logic [WORD_BITS-1:0]  b,
	input  logic [SHAMT_BITS-1:0] shift_amount,
	output ctl_t                  ctl,
	output logic [WORD_BITS-1:0]  a_out,
	output logic [WORD_BITS-1:0]  b_out
);

	logic a_neg, b_neg;

	assign a_neg = a[WORD_BITS-1];
	assign b_neg = b[WORD_BITS-1];

	always_comb begin
		ctl.op    = OP_NOP;
		ctl.err   = ERR_NONE;
		ctl.flip  = 1'b0;
		ctl.shamt = shift_amount;
		a_out     = a;
		b_out     = b;
		case (opcode)
			OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_NOT: begin
				ctl.op = op_t'(opcode);
			end
			OP_DIV: begin
				if (a == '0) begin
					ctl.op = OP_NOP;
				end else if (b == '0) begin
					ctl.err = ERR_DIV_ZERO;
				end else begin
					ctl.op   = OP_DIV;
					ctl.flip = a_neg ^ b_neg;
					a_out    = a_neg ? (WORD_BITS'(0) - a) : a;
					b_out    = b_neg ? (WORD_BITS'(0) - b) : b;
				end
			end
			OP_SHL: begin
				if (shift_amount == '0) ctl.err = ERR_SHIFT_ZERO;
				else ctl.op = OP_SHL;
			end
			default: ctl.op = OP_NOP;
		endcase
	end

endmodule

/* hdl/alu128_fifo.sv */
// small transaction queue between front and back end
module alu128_fifo
	import alu128_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

/* hdl/alu128_back.sv */
// back end: simple ops straight from the queue head, limb-serial multiply, restoring divide
module alu128_back
	import alu128_pkg::*;
#(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  ctl_t                 head_ctl,
	input  logic [WORD_BITS-1:0] head_a,
	input  logic [WORD_BITS-1:0] head_b,
	output logic                 pop,
	output logic                 done,
	output logic [WORD_BITS-1:0] result,
	output logic [1:0]           error_code
);

	localparam int LIMBS  = (WORD_BITS + LIMB_BITS - 1) / LIMB_BITS;
	localparam int PADW   = LIMBS * LIMB_BITS;
	localparam int LIW    = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int DCW    = $clog2(WORD_BITS);

	st_t                    st_q, st_d;
	logic [LIW-1:0]         i_q, i_d, j_q, j_d, sh_q, sh_d;
	logic [2*LIMB_BITS-1:0] prod_q, prod_d;
	logic                   pv_q, pv_d;
	logic [WORD_BITS-1:0]   acc_q, acc_d;
	logic [WORD_BITS-1:0]   rem_q, rem_d, quo_q, quo_d;
	logic [DCW-1:0]         cnt_q, cnt_d;
	logic                   done_q, done_d;
	logic [WORD_BITS-1:0]   res_q, res_d;
	err_t                   err_q, err_d;

	logic [PADW-1:0]        a_pad, b_pad, prod_sh;
	logic [LIMB_BITS-1:0]   a_limb, b_limb;
	logic [WORD_BITS-1:0]   trial, simple;
	logic                   ge;

	assign a_pad   = PADW'(head_a);
	assign b_pad   = PADW'(head_b);
	assign a_limb  = a_pad[i_q*LIMB_BITS +: LIMB_BITS];
	assign b_limb  = b_pad[j_q*LIMB_BITS +: LIMB_BITS];
	// place the registered partial product at its limb position
	assign prod_sh = PADW'(prod_q) << (sh_q * LIMB_BITS);

	assign trial = {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
	assign ge    = (trial >= head_b);

	always_comb begin
		case (head_ctl.op)
			OP_ADD:  simple = head_a + head_b;
			OP_SUB:  simple = head_a - head_b;
			OP_AND:  simple = head_a & head_b;
			OP_OR:   simple = head_a | head_b;
			OP_XOR:  simple = head_a ^ head_b;
			OP_NOT:  simple = ~head_a;
			OP_SHL:  simple = head_a << head_ctl.shamt;
			default: simple = '0;
		endcase
	end

	always_comb begin
		st_d   = st_q;
		i_d    = i_q;
		j_d    = j_q;
		sh_d   = sh_q;
		prod_d = prod_q;
		pv_d   = pv_q;
		acc_d  = acc_q;
		rem_d  = rem_q;
		quo_d  = quo_q;
		cnt_d  = cnt_q;
		done_d = 1'b0;
		res_d  = res_q;
		err_d  = err_q;
		pop    = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (head_valid) begin
					case (head_ctl.op)
						OP_MUL: begin
							st_d  = ST_MUL;
							i_d   = '0;
							j_d   = '0;
							pv_d  = 1'b0;
							acc_d = '0;
						end
						OP_DIV: begin
							st_d  = ST_DIV;
							rem_d = '0;
							quo_d = head_a;
							cnt_d = DCW'(WORD_BITS - 1);
						end
						default: begin
							pop    = 1'b1;
							done_d = 1'b1;
							res_d  = simple;
							err_d  = head_ctl.err;
						end
					endcase
				end
			end
			ST_MUL: begin
				prod_d = a_limb * b_limb;
				sh_d   = i_q + j_q;
				pv_d   = 1'b1;
				if (pv_q) acc_d = acc_q + WORD_BITS'(prod_sh);
				if (i_q == LIW'(LIMBS - 1)) begin
					st_d = ST_MUL_END;
				end else if (i_q + j_q == LIW'(LIMBS - 1)) begin
					i_d = i_q + 1'b1;
					j_d = '0;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_MUL_END: begin
				st_d   = ST_IDLE;
				pop    = 1'b1;
				done_d = 1'b1;
				res_d  = acc_q + WORD_BITS'(prod_sh);
				err_d  = ERR_NONE;
			end
			ST_DIV: begin
				rem_d = ge ? (trial - head_b) : trial;
				quo_d = {quo_q[WORD_BITS-2:0], ge};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) st_d = ST_DIV_END;
			end
			ST_DIV_END: begin
				st_d   = ST_IDLE;
				pop    = 1'b1;
				done_d = 1'b1;
				res_d  = head_ctl.flip ? (WORD_BITS'(0) - quo_q) : quo_q;
				err_d  = ERR_NONE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
			pv_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= done_d;
			pv_q   <= pv_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q    <= i_d;
		j_q    <= j_d;
		sh_q   <= sh_d;
		prod_q <= prod_d;
		acc_q  <= acc_d;
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		cnt_q  <= cnt_d;
		res_q  <= res_d;
		err_q  <= err_d;
	end

	assign done       = done_q;
	assign result     = res_q;
	assign error_code = err_q;

endmodule

/* hdl/signed_128bit_integer_alu_core.sv */
// top level of the signed integer alu: front end, queue, back end
//
// channel   | handshake      | payload
// ----------+----------------+--------------------------------------------
// command   | start / busy   | opcode, a_low, a_high, b_low, b_high, shift_amount
// result    | done (strobe)  | result_low, result_high, error_code
//
// a transaction is taken when start is high and busy is low; busy means the
// queue is full. add, sub, logic ops and shift leave one transaction per cycle
// while no multiply or divide holds the back end; each result is registered.
// multiply runs one 32x32 partial product per cycle, divide one quotient bit
// per cycle. reset clears queue and back end state; the receiver cannot stall
// results
module signed_128bit_integer_alu_core
	import alu128_pkg::*;
#(
	parameter int WORD_BITS  = DEF_WORD_BITS,
	parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [3:0]            opcode,
	input  logic [HALF_BITS-1:0]  a_low,
	input  logic [HALF_BITS-1:0]  a_high,
	input  logic [HALF_BITS-1:0]  b_low,
	input  logic [HALF_BITS-1:0]  b_high,
	input  logic [SHAMT_BITS-1:0] shift_amount,
	output logic                  done,
	output logic [HALF_BITS-1:0]  result_low,
	output logic [HALF_BITS-1:0]  result_high,
	output logic [1:0]            error_code
);

	localparam int ENTRY_W = $bits(ctl_t) + 2 * WORD_BITS;

	logic [FULL_BITS-1:0] a_full, b_full, res_full;
	logic [WORD_BITS-1:0] a_w, b_w, fa, fb, ha, hb, res_w;
	ctl_t                 fctl, hctl;
	logic [ENTRY_W-1:0]   wentry, rentry;
	logic                 push, pop, empty, full;

	// operands reduced to the word width
	assign a_full = {a_high, a_low};
	assign b_full = {b_high, b_low};
	assign a_w    = a_full[WORD_BITS-1:0];
	assign b_w    = b_full[WORD_BITS-1:0];

	alu128_front #(.WORD_BITS(WORD_BITS)) u_front (
		.opcode       (opcode),
		.a            (a_w),
		.b            (b_w),
		.shift_amount (shift_amount),
		.ctl          (fctl),
		.a_out        (fa),
		.b_out        (fb)
	);

	assign busy   = full;
	assign push   = start && !full;
	assign wentry = {fctl, fa, fb};

	alu128_fifo #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.pop    (pop),
		.rdata  (rentry),
		.empty  (empty),
		.full   (full)
	);

	assign {hctl, ha, hb} = rentry;

	alu128_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!empty),
		.head_ctl   (hctl),
		.head_a     (ha),
		.head_b     (hb),
		.pop        (pop),
		.done       (done),
		.result     (res_w),
		.error_code (error_code)
	);

	// bits above the word width read as zero
	assign res_full    = FULL_BITS'(res_w);
	assign result_low  = res_full[HALF_BITS-1:0];
	assign result_high = res_full[FULL_BITS-1:HALF_BITS];

endmodule
